[sv/pstd_pkg.sv]
`timescale 1ns / 1ps
// Shared types and constants for the prime split trial-division unit.
// Holds the microcode word layout and datapath widths; no dependencies.
package pstd_pkg;

  localparam int NUM_W         = 16;            // width of the value field
  localparam int POS_W         = 10;            // width of a list position
  localparam int DIV_W         = NUM_W / 2 + 1; // divisor and remainder width
  localparam int BIT_W         = $clog2(NUM_W); // bit index of the long division
  localparam int PC_W          = 3;             // microprogram counter width

  localparam int VALUE_BITS_DEF = 16;
  localparam int MAX_SET_DEF    = 1024;

  typedef enum logic [2:0] {
    OP_NOP,
    OP_WAIT,
    OP_SMALL,
    OP_SQUARE,
    OP_DIV,
    OP_REM,
    OP_EMIT
  } op_e;

  typedef enum logic [1:0] {
    SEQ_JUMP,
    SEQ_IF_FLAG,
    SEQ_HOLD_IF_FLAG
  } seq_e;

  typedef logic [PC_W-1:0] upc_t;

  typedef struct packed {
    op_e  op;
    seq_e seq;
    upc_t target;
  } uword_t;

  localparam upc_t UPC_WAIT   = 3'd0;
  localparam upc_t UPC_SMALL  = 3'd1;
  localparam upc_t UPC_SQUARE = 3'd2;
  localparam upc_t UPC_DIV    = 3'd3;
  localparam upc_t UPC_REM    = 3'd4;
  localparam upc_t UPC_EMIT   = 3'd5;

endpackage

[sv/pstd_if.sv]
`timescale 1ns / 1ps
// Valid/ready channel interfaces for the input items and the result items.
// Depends on pstd_pkg for the field widths.
interface pstd_in_if;
  logic                        valid;
  logic                        ready;
  logic [pstd_pkg::NUM_W-1:0]  value;
  logic                        last_of_set;

  modport source (output valid, output value, output last_of_set, input ready);
  modport sink   (input valid, input value, input last_of_set, output ready);
endinterface

interface pstd_out_if;
  logic                        valid;
  logic                        ready;
  logic [pstd_pkg::NUM_W-1:0]  number;
  logic                        is_prime;
  logic [pstd_pkg::POS_W-1:0]  list_position;
  logic                        end_of_set;

  modport source (output valid, output number, output is_prime, output list_position,
                  output end_of_set, input ready);
  modport sink   (input valid, input number, input is_prime, input list_position,
                  input end_of_set, output ready);
endinterface

[sv/pstd_sequencer.sv]
`timescale 1ns / 1ps
// Microprogram counter and control store of the trial-division unit.
// Depends on pstd_pkg for the control word and the opcode encoding.
module pstd_sequencer (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          flag_i,
  output pstd_pkg::op_e op_o
);
  import pstd_pkg::*;

  upc_t   pc_q, pc_d;
  uword_t uword;

  // Control store. The flag comes back from the datapath and means
  // something different for each opcode.
  always_comb begin
    case (pc_q)
      UPC_WAIT:   uword = '{op: OP_WAIT,   seq: SEQ_HOLD_IF_FLAG, target: UPC_SMALL};
      UPC_SMALL:  uword = '{op: OP_SMALL,  seq: SEQ_IF_FLAG,      target: UPC_EMIT};
      UPC_SQUARE: uword = '{op: OP_SQUARE, seq: SEQ_IF_FLAG,      target: UPC_EMIT};
      UPC_DIV:    uword = '{op: OP_DIV,    seq: SEQ_HOLD_IF_FLAG, target: UPC_REM};
      UPC_REM:    uword = '{op: OP_REM,    seq: SEQ_IF_FLAG,      target: UPC_SQUARE};
      UPC_EMIT:   uword = '{op: OP_EMIT,   seq: SEQ_HOLD_IF_FLAG, target: UPC_WAIT};
      default:    uword = '{op: OP_NOP,    seq: SEQ_JUMP,         target: UPC_WAIT};
    endcase
  end

  always_comb begin
    case (uword.seq)
      SEQ_JUMP:         pc_d = uword.target;
      SEQ_IF_FLAG:      pc_d = flag_i ? uword.target : pc_q + 1'b1;
      SEQ_HOLD_IF_FLAG: pc_d = flag_i ? pc_q : uword.target;
      default:          pc_d = UPC_WAIT;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pc_q <= UPC_WAIT;
    end else begin
      pc_q <= pc_d;
    end
  end

  assign op_o = uword.op;

endmodule

[sv/pstd_datapath.sv]
`timescale 1ns / 1ps
// Datapath of the trial-division unit: value and divisor registers, a
// one-bit-per-cycle remainder unit, the two list counters and the result
// register. Depends on pstd_pkg and the channel interfaces in pstd_if.
module pstd_datapath #(
  parameter int VALUE_BITS = pstd_pkg::VALUE_BITS_DEF,
  parameter int MAX_SET    = pstd_pkg::MAX_SET_DEF
) (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  pstd_pkg::op_e op_i,
  output logic          flag_o,
  pstd_in_if.sink       in_i,
  pstd_out_if.source    out_o
);
  import pstd_pkg::*;

  localparam int EffBits = (VALUE_BITS < NUM_W) ? VALUE_BITS : NUM_W;
  localparam logic [NUM_W-1:0] ValMask = {NUM_W{1'b1}} >> (NUM_W - EffBits);
  localparam int WrapAt = (MAX_SET < (1 << POS_W)) ? MAX_SET : (1 << POS_W);

  logic [NUM_W-1:0]   val_q;
  logic               last_q;
  logic [DIV_W-1:0]   div_q;
  logic [DIV_W-1:0]   rem_q;
  logic [BIT_W-1:0]   bit_q;
  logic               prime_q;
  logic [POS_W-1:0]   pcnt_q, pcnt_d;
  logic [POS_W-1:0]   kcnt_q, kcnt_d;
  logic               out_valid_q, out_valid_d;

  logic [NUM_W-1:0]   number_q;
  logic               is_prime_q;
  logic [POS_W-1:0]   pos_q;
  logic               end_q;

  logic               accept;
  logic               out_busy;
  logic               emit;
  logic [2*DIV_W-1:0] square;
  logic [DIV_W:0]     shifted;
  logic [DIV_W-1:0]   rem_next;
  logic [POS_W-1:0]   pos;

  function automatic logic [POS_W-1:0] bump(input logic [POS_W-1:0] c);
    logic [POS_W:0] n;
    n = {1'b0, c} + 1'b1;
    return (n >= (POS_W+1)'(WrapAt)) ? '0 : n[POS_W-1:0];
  endfunction

  assign in_i.ready = (op_i == OP_WAIT);
  assign accept     = in_i.valid && in_i.ready;
  assign out_busy   = out_valid_q && !out_o.ready;
  assign emit       = (op_i == OP_EMIT) && !out_busy;

  // Trial division stops once the divisor squared passes the value.
  assign square   = div_q * div_q;
  // Restoring long division step: bring down one bit of the value.
  assign shifted  = {rem_q, val_q[bit_q]};
  assign rem_next = (shifted >= {1'b0, div_q}) ? DIV_W'(shifted - {1'b0, div_q})
                                                : shifted[DIV_W-1:0];
  assign pos      = prime_q ? pcnt_q : kcnt_q;

  always_comb begin
    case (op_i)
      OP_WAIT:   flag_o = !accept;
      OP_SMALL:  flag_o = (val_q < NUM_W'(2));
      OP_SQUARE: flag_o = (square > (2*DIV_W)'(val_q));
      OP_DIV:    flag_o = (bit_q != '0);
      OP_REM:    flag_o = (rem_q != '0);
      OP_EMIT:   flag_o = out_busy;
      default:   flag_o = 1'b0;
    endcase
  end

  always_ff @(posedge clk_i) begin
    case (op_i)
      OP_WAIT: begin
        if (accept) begin
          val_q  <= in_i.value & ValMask;
          last_q <= in_i.last_of_set;
        end
      end
      OP_SMALL: begin
        div_q   <= DIV_W'(2);
        prime_q <= 1'b0;
      end
      OP_SQUARE: begin
        prime_q <= 1'b1;
        rem_q   <= '0;
        bit_q   <= BIT_W'(NUM_W - 1);
      end
      OP_DIV: begin
        rem_q <= rem_next;
        bit_q <= bit_q - 1'b1;
      end
      OP_REM: begin
        // After two, only odd divisors are worth trying.
        if (rem_q == '0) begin
          prime_q <= 1'b0;
        end else if (div_q == DIV_W'(2)) begin
          div_q <= DIV_W'(3);
        end else begin
          div_q <= div_q + DIV_W'(2);
        end
      end
      default: begin
      end
    endcase
    if (emit) begin
      number_q   <= val_q;
      is_prime_q <= prime_q;
      pos_q      <= pos;
      end_q      <= last_q;
    end
  end

  always_comb begin
    pcnt_d      = pcnt_q;
    kcnt_d      = kcnt_q;
    out_valid_d = out_valid_q;
    if (out_o.ready) begin
      out_valid_d = 1'b0;
    end
    if (emit) begin
      out_valid_d = 1'b1;
      if (last_q) begin
        pcnt_d = '0;
        kcnt_d = '0;
      end else if (prime_q) begin
        pcnt_d = bump(pcnt_q);
      end else begin
        kcnt_d = bump(kcnt_q);
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pcnt_q      <= '0;
      kcnt_q      <= '0;
      out_valid_q <= 1'b0;
    end else begin
      pcnt_q      <= pcnt_d;
      kcnt_q      <= kcnt_d;
      out_valid_q <= out_valid_d;
    end
  end

  assign out_o.valid         = out_valid_q;
  assign out_o.number        = number_q;
  assign out_o.is_prime      = is_prime_q;
  assign out_o.list_position = pos_q;
  assign out_o.end_of_set    = end_q;

endmodule

[sv/prime_split_trial_division_unit.sv]
`timescale 1ns / 1ps
// Classifies each input value as prime or not by trial division and reports
// its position in the prime list or the kept list; an item with last_of_set
// clears both counts after its own result. Values 0 and 1 are not prime.
// One item is worked on at a time, under a six-step microprogram. A value
// below two goes from the small-value check straight to the emit step.
// Otherwise each divisor tried (two, then the odd numbers up to the square
// root) passes through the square check, the division step and the
// remainder check, and the remainder is formed one bit per cycle over all 16
// bits of the value. The emit step waits while an earlier result is still
// undelivered; the unit then returns to the wait step, ready for the next
// item. The result waits in an output register, so the next item is taken
// while it is still undelivered.
// Depends on pstd_pkg, pstd_if, pstd_sequencer and pstd_datapath.
module prime_split_trial_division_unit #(
  parameter int VALUE_BITS = pstd_pkg::VALUE_BITS_DEF,
  parameter int MAX_SET    = pstd_pkg::MAX_SET_DEF
) (
  input  logic       clk_i,
  input  logic       rst_ni,
  pstd_in_if.sink    in_i,
  pstd_out_if.source out_o
);
  import pstd_pkg::*;

  op_e  op;
  logic flag;

  pstd_sequencer u_seq (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .flag_i (flag),
    .op_o   (op)
  );

  pstd_datapath #(
    .VALUE_BITS (VALUE_BITS),
    .MAX_SET    (MAX_SET)
  ) u_dp (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .op_i   (op),
    .flag_o (flag),
    .in_i   (in_i),
    .out_o  (out_o)
  );

endmodule
